FILE: sv/drt_pkg.sv
// Package of types, constants and helpers for the dirty rectangle tracker.
`default_nettype none
package drt_pkg;
    localparam int MAX_RECTS = 4;
    localparam int NEAR_GAP  = 24;
    localparam int MAX_DIM   = 4096;
    localparam int CW = 13;
    localparam int IDX_W = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
    localparam int CNT_W = $clog2(MAX_RECTS + 1);

    localparam logic [1:0] OP_MARK    = 2'd0;
    localparam logic [1:0] OP_MARKALL = 2'd1;
    localparam logic [1:0] OP_PRESENT = 2'd2;

    localparam logic [2:0] REG_SCREEN_W = 3'd0;
    localparam logic [2:0] REG_SCREEN_H = 3'd1;
    localparam logic [2:0] REG_CLIP_L   = 3'd2;
    localparam logic [2:0] REG_CLIP_T   = 3'd3;
    localparam logic [2:0] REG_CLIP_W   = 3'd4;
    localparam logic [2:0] REG_CLIP_H   = 3'd5;

    typedef struct packed {
        logic [CW-1:0] x0;
        logic [CW-1:0] y0;
        logic [CW-1:0] x1;
        logic [CW-1:0] y1;
    } box_t;

    // Command sent down the chain of cells.
    typedef enum logic [2:0] {
        CC_NONE,
        CC_CONTAIN,
        CC_CLOSE,
        CC_GROW,
        CC_SHIFT,
        CC_LOAD
    } cell_cmd_t;

    typedef struct packed {
        cell_cmd_t     cmd;
        box_t          box;
        logic [IDX_W-1:0] idx;
    } cell_bus_t;

    // Answer travelling back from a cell.
    typedef struct packed {
        logic          hit;
        logic [25:0]   growth;
    } cell_ans_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLIP,
        ST_CONTAIN,
        ST_CLOSE,
        ST_ABSORB,
        ST_APPEND,
        ST_GROW,
        ST_GROW_PICK,
        ST_PRESENT,
        ST_OUT
    } state_t;

    function automatic logic [CW-1:0] cmin(input logic [CW-1:0] a, input logic [CW-1:0] b);
        return (a < b) ? a : b;
    endfunction

    function automatic logic [CW-1:0] cmax(input logic [CW-1:0] a, input logic [CW-1:0] b);
        return (a > b) ? a : b;
    endfunction

    function automatic box_t unite(input box_t a, input box_t b);
        box_t r;
        r.x0 = cmin(a.x0, b.x0);
        r.y0 = cmin(a.y0, b.y0);
        r.x1 = cmax(a.x1, b.x1);
        r.y1 = cmax(a.y1, b.y1);
        return r;
    endfunction
endpackage
`default_nettype wire

FILE: sv/drt_if.sv
// Valid/ready channel interfaces of the dirty rectangle tracker.
`default_nettype none
interface drt_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic signed [15:0] region_x;
    logic signed [15:0] region_y;
    logic signed [15:0] region_w;
    logic signed [15:0] region_h;
    modport source (output valid, operation, region_x, region_y, region_w, region_h,
                    input ready);
    modport sink (input valid, operation, region_x, region_y, region_w, region_h,
                  output ready);
endinterface

interface drt_out_if;
    logic        valid;
    logic        ready;
    logic [12:0] rect_left;
    logic [12:0] rect_top;
    logic [12:0] rect_right;
    logic [12:0] rect_bottom;
    logic [24:0] rect_area;
    logic [26:0] total_area;
    logic        last;
    modport source (output valid, rect_left, rect_top, rect_right, rect_bottom, rect_area,
                    total_area, last, input ready);
    modport sink (input valid, rect_left, rect_top, rect_right, rect_bottom, rect_area,
                  total_area, last, output ready);
endinterface

interface drt_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [15:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

FILE: sv/drt_cell.sv
// One storage cell of the rectangle chain: holds a box and answers one query.
`default_nettype none
module drt_cell
    import drt_pkg::*;
(
    input  wire logic      clk,
    input  wire logic [IDX_W-1:0] my_idx,
    input  wire cell_bus_t bus_in,
    input  wire box_t      last_box,
    output box_t           box_q,
    output cell_ans_t      ans
);
    box_t box_reg;
    box_t box_next;
    box_t u;
    logic [13:0] gx0, gy0;
    logic [25:0] a_old, a_new;
    logic [12:0] uw, uh, ow, oh;

    always_comb
    begin
        u = unite(box_reg, bus_in.box);
        uw = u.x1 - u.x0;
        uh = u.y1 - u.y0;
        ow = box_reg.x1 - box_reg.x0;
        oh = box_reg.y1 - box_reg.y0;
        a_new = 26'(uw) * 26'(uh);
        a_old = 26'(ow) * 26'(oh);
        gx0 = 14'(box_reg.x1) + 14'(NEAR_GAP);
        gy0 = 14'(bus_in.box.x1) + 14'(NEAR_GAP);
        ans.hit = 1'b0;
        ans.growth = a_new - a_old;
        unique case (bus_in.cmd)
            CC_CONTAIN: ans.hit = box_reg.x0 <= bus_in.box.x0 && box_reg.y0 <= bus_in.box.y0
                               && box_reg.x1 >= bus_in.box.x1 && box_reg.y1 >= bus_in.box.y1;
            CC_CLOSE:   ans.hit = 14'(bus_in.box.x0) <= gx0 && 14'(box_reg.x0) <= gy0
                   && 14'(bus_in.box.y0) <= 14'(box_reg.y1) + 14'(NEAR_GAP)
                   && 14'(box_reg.y0) <= 14'(bus_in.box.y1) + 14'(NEAR_GAP);
            default:    ans.hit = 1'b0;
        endcase
        box_next = box_reg;
        if (bus_in.idx == my_idx)
        begin
            unique case (bus_in.cmd)
                CC_LOAD:  box_next = bus_in.box;
                CC_SHIFT: box_next = last_box;
                CC_GROW:  box_next = u;
                default:  box_next = box_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        box_reg <= box_next;
    end

    assign box_q = box_reg;
endmodule
`default_nettype wire

FILE: sv/drt_chain.sv
// Row of rectangle cells; every cell sees the controller's command in the same cycle.
`default_nettype none
module drt_chain
    import drt_pkg::*;
(
    input  wire logic      clk,
    input  wire cell_bus_t bus,
    input  wire logic [IDX_W-1:0] last_idx,
    output box_t           boxes [MAX_RECTS],
    output cell_ans_t      answers [MAX_RECTS]
);
    box_t last_box;

    assign last_box = boxes[last_idx];

    genvar g;
    generate
        for (g = 0; g < MAX_RECTS; g++)
        begin : g_cell
            drt_cell u_cell (
                .clk(clk), .my_idx(IDX_W'(g)), .bus_in(bus), .last_box(last_box),
                .box_q(boxes[g]), .ans(answers[g]));
        end
    endgenerate
endmodule
`default_nettype wire

FILE: sv/dirty_rectangle_tracker_top.sv
// Top level of the dirty rectangle tracker: control sequencer, clipping and output.
// The tracker keeps up to four dirty rectangles in a row of storage cells. After the
// input item is accepted, a mark item is clipped and dropped when empty. With an empty
// store it goes straight to the append; else it is checked for containment, then
// probes for a nearby entry, each hit adding an absorb of that entry before the next
// probe, and it ends with an append. When the store is full the append is replaced by a
// growth choice (ST_GROW, then ST_GROW_PICK). Mark-all is handled in the cycle in which
// it is accepted. Present delivers the stored rectangles, one result item per cycle while
// the sink is ready; a stalled sink holds the sequencer. Configuration writes are taken
// at any time and must only be issued while the block is idle. No input item is taken
// while an earlier item is still in work.
`default_nettype none
module dirty_rectangle_tracker_top
    import drt_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    drt_cfg_if.sink   cfg,
    drt_in_if.sink    in_ch,
    drt_out_if.source out_ch
);
    logic [12:0] scr_w_reg, scr_h_reg, clip_w_reg, clip_h_reg;
    logic signed [15:0] clip_l_reg, clip_t_reg;

    state_t state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic signed [17:0] rx0_reg, ry0_reg, rx1_reg, ry1_reg;
    box_t n_reg, n_next;
    logic [CNT_W-1:0] pidx_reg, pidx_next;
    logic [26:0] total_reg, total_next;
    logic [IDX_W-1:0] best_reg, best_next;
    logic [25:0] bestg_next;

    logic ov_reg;
    box_t ob_reg;
    logic [24:0] oa_reg;
    logic [26:0] ot_reg;
    logic ol_reg;

    cell_bus_t bus;
    box_t boxes [MAX_RECTS];
    cell_ans_t answers [MAX_RECTS];
    logic [IDX_W-1:0] last_idx;

    box_t pbox;
    logic [24:0] parea;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scr_w_reg <= '0; scr_h_reg <= '0; clip_w_reg <= '0; clip_h_reg <= '0;
            clip_l_reg <= '0; clip_t_reg <= '0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_SCREEN_W: scr_w_reg <= cfg.data[12:0];
                REG_SCREEN_H: scr_h_reg <= cfg.data[12:0];
                REG_CLIP_L:   clip_l_reg <= cfg.data;
                REG_CLIP_T:   clip_t_reg <= cfg.data;
                REG_CLIP_W:   clip_w_reg <= cfg.data[12:0];
                REG_CLIP_H:   clip_h_reg <= cfg.data[12:0];
                default: ;
            endcase
        end
    end

    // Screen size saturated to the largest supported dimension.
    logic [12:0] sw, sh;
    assign sw = (scr_w_reg > 13'(MAX_DIM)) ? 13'(MAX_DIM) : scr_w_reg;
    assign sh = (scr_h_reg > 13'(MAX_DIM)) ? 13'(MAX_DIM) : scr_h_reg;

    // Clipping in 18-bit signed arithmetic on the captured region.
    logic signed [17:0] cx0, cy0, cx1, cy1, cr, cb;
    logic clip_empty;
    always_comb
    begin
        cr = 18'(clip_l_reg) + 18'($signed({1'b0, clip_w_reg}));
        cb = 18'(clip_t_reg) + 18'($signed({1'b0, clip_h_reg}));
        cx0 = rx0_reg; cy0 = ry0_reg; cx1 = rx1_reg; cy1 = ry1_reg;
        if (clip_w_reg != '0)
        begin
            if (cx0 < 18'(clip_l_reg)) cx0 = 18'(clip_l_reg);
            if (cy0 < 18'(clip_t_reg)) cy0 = 18'(clip_t_reg);
            if (cx1 > cr) cx1 = cr;
            if (cy1 > cb) cy1 = cb;
        end
        if (cx0 < 0) cx0 = '0;
        if (cy0 < 0) cy0 = '0;
        if (cx1 > $signed({5'd0, sw})) cx1 = $signed({5'd0, sw});
        if (cy1 > $signed({5'd0, sh})) cy1 = $signed({5'd0, sh});
        clip_empty = !(cx0 < cx1 && cy0 < cy1);
    end

    // Scan of cell answers, lowest index first, below the fill count.
    logic any_hit;
    logic [IDX_W-1:0] hit_idx;
    always_comb
    begin
        any_hit = 1'b0;
        hit_idx = '0;
        for (int i = MAX_RECTS - 1; i >= 0; i--)
        begin
            if (answers[i].hit && CNT_W'(i) < count_reg)
            begin
                any_hit = 1'b1;
                hit_idx = IDX_W'(i);
            end
        end
    end

    assign last_idx = IDX_W'(count_reg - CNT_W'(1));

    logic out_free;
    assign out_free = !ov_reg || out_ch.ready;
    assign in_ch.ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (in_ch.valid)
                begin
                    priority case (in_ch.operation)
                        OP_MARK:    state_next = ST_CLIP;
                        OP_PRESENT: state_next = (count_reg == '0) ? ST_IDLE : ST_PRESENT;
                        default:    state_next = ST_IDLE;
                    endcase
                end
            ST_CLIP:     state_next = clip_empty ? ST_IDLE
                                    : ((count_reg == '0) ? ST_APPEND : ST_CONTAIN);
            ST_CONTAIN:  state_next = any_hit ? ST_IDLE : ST_CLOSE;
            ST_CLOSE:    state_next = any_hit ? ST_ABSORB
                                    : ((count_reg == CNT_W'(MAX_RECTS)) ? ST_GROW : ST_APPEND);
            ST_ABSORB:   state_next = (count_reg == CNT_W'(1)) ? ST_APPEND : ST_CLOSE;
            ST_APPEND:   state_next = ST_IDLE;
            ST_GROW:     state_next = ST_GROW_PICK;
            ST_GROW_PICK: state_next = ST_IDLE;
            ST_PRESENT:  state_next = out_free ? ((pidx_reg + CNT_W'(1) == count_reg)
                                    ? ST_OUT : ST_PRESENT) : ST_PRESENT;
            ST_OUT:      state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        bus.cmd = CC_NONE;
        bus.box = n_reg;
        bus.idx = '0;
        count_next = count_reg;
        n_next = n_reg;
        pidx_next = pidx_reg;
        total_next = total_reg;
        best_next = best_reg;
        bestg_next = '0;
        unique case (state_reg)
            ST_IDLE:
                if (in_ch.valid && in_ch.operation == OP_MARKALL)
                begin
                    bus.cmd = CC_LOAD;
                    bus.box = '{x0: '0, y0: '0, x1: sw, y1: sh};
                    count_next = CNT_W'(1);
                end
                else
                begin
                    pidx_next = '0;
                    total_next = '0;
                end
            ST_CLIP:
                n_next = '{x0: cx0[12:0], y0: cy0[12:0], x1: cx1[12:0], y1: cy1[12:0]};
            ST_CONTAIN: bus.cmd = CC_CONTAIN;
            ST_CLOSE:
            begin
                bus.cmd = CC_CLOSE;
                best_next = hit_idx;
            end
            ST_ABSORB:
            begin
                n_next = unite(n_reg, boxes[best_reg]);
                bus.cmd = CC_SHIFT;
                bus.idx = best_reg;
                count_next = count_reg - CNT_W'(1);
            end
            ST_APPEND:
            begin
                bus.cmd = CC_LOAD;
                bus.idx = IDX_W'(count_reg);
                count_next = count_reg + CNT_W'(1);
            end
            ST_GROW:
            begin
                // Every cell reports its growth against the region without changing its box.
                best_next = '0;
                bestg_next = answers[0].growth;
                for (int i = 1; i < MAX_RECTS; i++)
                    if (answers[i].growth < bestg_next)
                    begin
                        bestg_next = answers[i].growth;
                        best_next = IDX_W'(i);
                    end
            end
            ST_GROW_PICK:
            begin
                bus.cmd = CC_GROW;
                bus.idx = best_reg;
            end
            ST_PRESENT:
                if (out_free)
                begin
                    pidx_next = pidx_reg + CNT_W'(1);
                    total_next = total_reg + 27'(parea);
                end
            ST_OUT: count_next = '0;
            default: ;
        endcase
    end

    // Area of the box being presented.
    assign pbox = boxes[IDX_W'(pidx_reg)];
    assign parea = 25'(26'(pbox.x1 - pbox.x0) * 26'(pbox.y1 - pbox.y0));

    drt_chain u_chain (
        .clk(clk), .bus(bus), .last_idx(last_idx),
        .boxes(boxes), .answers(answers));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            ov_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (state_reg == ST_PRESENT && out_free)
                ov_reg <= 1'b1;
            else if (out_ch.ready)
                ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && in_ch.valid)
        begin
            rx0_reg <= 18'(in_ch.region_x);
            ry0_reg <= 18'(in_ch.region_y);
            rx1_reg <= 18'(in_ch.region_x) + 18'(in_ch.region_w);
            ry1_reg <= 18'(in_ch.region_y) + 18'(in_ch.region_h);
        end
        n_reg <= n_next;
        pidx_reg <= pidx_next;
        best_reg <= best_next;
        if (state_reg == ST_PRESENT && out_free)
        begin
            ob_reg <= pbox;
            oa_reg <= parea;
            ot_reg <= total_next;
            ol_reg <= (pidx_reg + CNT_W'(1) == count_reg);
        end
        total_reg <= total_next;
    end

    assign out_ch.valid = ov_reg;
    assign out_ch.rect_left = ob_reg.x0;
    assign out_ch.rect_top = ob_reg.y0;
    assign out_ch.rect_right = ob_reg.x1;
    assign out_ch.rect_bottom = ob_reg.y1;
    assign out_ch.rect_area = oa_reg;
    assign out_ch.total_area = ot_reg;
    assign out_ch.last = ol_reg;
endmodule
`default_nettype wire
